>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Plain condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    `ASSERT_CLK(label, clk, rstn, cond, msg)

`endif

>>> rtl/core/crc32rb_pkg.sv
// ----------------------------------------------------------------------------
// crc32rb_pkg
// Constants, types and table for the reflected byte-wise CRC-32 unit.
// ----------------------------------------------------------------------------
package crc32rb_pkg;

    localparam int unsigned CRC_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TABLE_N = 256;

    localparam logic [CRC_W-1:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_FINAL_XOR = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_RESET_VAL = 32'h0000_0000;

    typedef logic [CRC_W-1:0] crc_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef crc_t crc_table_t [TABLE_N];

    function automatic crc_t crc32rb_entry(input byte_t idx);
        crc_t v;
        v = {{(CRC_W-BYTE_W){1'b0}}, idx};
        for (int k = 0; k < BYTE_W; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

    function automatic crc_table_t crc32rb_build_table();
        crc_table_t t;
        for (int i = 0; i < TABLE_N; i++) begin
            t[i] = crc32rb_entry(i[BYTE_W-1:0]);
        end
        return t;
    endfunction

    localparam crc_table_t CRC_TABLE = crc32rb_build_table();

endpackage

>>> rtl/core/crc32_reflected_byte_stream_unit.sv
// ----------------------------------------------------------------------------
// crc32_reflected_byte_stream_unit
// Byte stream CRC-32 (reflected, poly EDB88320) with programmable start value.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one byte per item in s_tdata, s_tuser marks the first byte of
//   a message (remainder loaded from the start value), s_tlast the last byte.
//   m_ channel: one item per message, the checksum (remainder ^ FFFFFFFF),
//   sent after the item carrying s_tlast.
//   cfg channel: writes the start value; always ready, write only when idle.
// Path: a last byte goes from the input register through the table lookup
//   and xor into the result register, which drives m_tvalid.
// Throughput: one byte per cycle but for the stall below; the single table
//   lookup and xor between the input and remainder registers set the rate.
// Stall: while a checksum waits in the result register, non-last bytes keep
//   flowing; a further last byte waits in the input register and s_tready
//   drops until m_tready takes the pending checksum.
// Reset: clears start value and remainder to zero and empties both stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc32_reflected_byte_stream_unit
    import crc32rb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] checksum
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    crc_t  start_value_reg;
    crc_t  remainder_reg;
    byte_t in_byte_reg;
    logic  in_first_reg;
    logic  in_last_reg;
    logic  in_valid_reg;
    crc_t  out_data_reg;
    logic  out_valid_reg;
    crc_t  remainder_next;
    logic  advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    crc32rb_update u_update (
        .remainder      (remainder_reg),
        .start_value    (start_value_reg),
        .data_byte      (in_byte_reg),
        .first_byte     (in_first_reg),
        .remainder_next (remainder_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_value_reg <= CRC_RESET_VAL;
            remainder_reg   <= CRC_RESET_VAL;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                start_value_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                remainder_reg <= remainder_next;
            end
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_data_reg <= remainder_next ^ CRC_FINAL_XOR;
        end
    end

    `ASSERT_CLK(a_last_gives_result, aclk, aresetn,
        advance && in_last_reg |=> out_valid_reg,
        "last byte did not produce a result")
    `ASSERT_CLK(a_remainder_follows, aclk, aresetn,
        advance |=> remainder_reg == $past(remainder_next),
        "remainder not updated by consumed byte")
    `ASSERT_ALWAYS(a_stall_only_on_pending, aclk, aresetn,
        !s_tready |-> in_valid_reg && in_last_reg && out_valid_reg && !m_tready,
        "input stalled without a pending result")

endmodule

>>> rtl/core/crc32rb_update.sv
// ----------------------------------------------------------------------------
// crc32rb_update
// One byte step of the reflected CRC-32 remainder, with start-value load.
// ----------------------------------------------------------------------------
module crc32rb_update
    import crc32rb_pkg::*;
(
    input  crc_t  remainder,
    input  crc_t  start_value,
    input  byte_t data_byte,
    input  logic  first_byte,
    output crc_t  remainder_next
);

    crc_t  base;
    byte_t idx;

    always_comb begin
        base           = first_byte ? start_value : remainder;
        idx            = base[BYTE_W-1:0] ^ data_byte;
        remainder_next = CRC_TABLE[idx] ^ (base >> BYTE_W);
    end

endmodule
